// File: design/pvoc_pkg.sv
// Shared constants, types and a helper function for the periodic vertex order classifier.
// Has no dependencies. The top-level module imports it.
package pvoc_pkg;

    // Parameter width as seen by the datapath. Widths of 32 and above behave as 32.
    localparam int PARAM_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int EFF_W       = (PARAM_WIDTH > FIELD_W) ? FIELD_W : PARAM_WIDTH;
    localparam int SEXT_SH     = FIELD_W - EFF_W;

    localparam int ORIENT_W    = 2;
    localparam int PERIOD_W    = 31;
    localparam int TOL_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Difference of two parameters, adjusted values, and the tolerance compare width
    localparam int DIFF_W      = FIELD_W + 1;
    localparam int VAL_W       = FIELD_W + 2;
    localparam int CMP_W       = FIELD_W + 3;

    // One remainder bit per stage over the magnitude of the difference
    localparam int DIV_STAGES  = FIELD_W;
    localparam int NUM_LANES   = 2;

    typedef logic signed [FIELD_W-1:0] t_param;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [VAL_W-1:0]   t_val;
    typedef logic signed [CMP_W-1:0]   t_cmp;

    typedef enum logic [ORIENT_W-1:0] {
        OR_FORWARD  = 2'd0,
        OR_REVERSED = 2'd1,
        OR_INTERNAL = 2'd2,
        OR_EXTERNAL = 2'd3
    } t_orient;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIODIC = 3'd0,
        REG_SAME     = 3'd1,
        REG_FIRST    = 3'd2,
        REG_PERIOD   = 3'd3,
        REG_TOL      = 3'd4
    } t_reg_idx;

    // How the adjusted value of a lane is formed
    typedef enum logic [1:0] {
        ADJ_KEEP,
        ADJ_ADD_P,
        ADJ_WRAP
    } t_adj;

    // Per-lane sideband that travels alongside the remainder pipeline
    typedef struct packed {
        t_param  p;
        t_param  base;
        t_orient o;
        t_adj    cat;
        logic    neg;
    } t_lane;

    // Partial remainder and the dividend bits still to be shifted in
    typedef struct packed {
        logic [PERIOD_W-1:0] rem;
        logic [FIELD_W-1:0]  dvd;
    } t_div;

    // Truncate to the parameter width and sign-extend back to the field width
    function automatic t_param sext_param(input logic [FIELD_W-1:0] v);
        sext_param = t_param'($signed(v << SEXT_SH) >>> SEXT_SH);
    endfunction

endpackage

// File: design/periodic_vertex_order_classifier_unit.sv
// Periodic vertex order classifier: top level with the full datapath pipeline.
// Depends on pvoc_pkg for constants, types and the parameter sign-extension function.
//
// Usage:
//   An item (param_a, orient_a, param_b, orient_b) is taken at a rising edge where
//   start is high and busy is low. busy never rises, so a new item can be taken in
//   every cycle. Each item gives exactly one result: o_is_outside, shown for one
//   cycle with o_done high. Results leave in the order the items came in.
//   Throughput: one item per cycle.
//   Most of the pipeline is the remainder unit: the wrap of a periodic parameter takes
//   one remainder bit per stage over a 32-bit magnitude, with both parameters worked
//   in two lanes side by side. Before the remainder unit come a difference stage and
//   a tolerance stage. After it come a sign fix-up stage, a value stage and the
//   compare at the output register.
//   Configuration: i_cfg_we, i_cfg_idx and i_cfg_wdata write one register per edge.
//   Write only while no items are in flight. A write to an index that does not exist
//   is ignored.
//   Reset (i_rst_n low at an edge) empties the pipeline and sets tolerance to 1 and
//   all other registers to 0. The receiver cannot stall, so every result is shown
//   exactly once.
module periodic_vertex_order_classifier_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [pvoc_pkg::FIELD_W-1:0]  i_param_a,
    input  logic [pvoc_pkg::ORIENT_W-1:0]        i_orient_a,
    input  logic signed [pvoc_pkg::FIELD_W-1:0]  i_param_b,
    input  logic [pvoc_pkg::ORIENT_W-1:0]        i_orient_b,
    input  logic                                 i_cfg_we,
    input  logic [pvoc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pvoc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output logic                                 o_done,
    output logic                                 o_is_outside
);
    import pvoc_pkg::*;

    // Configuration registers
    logic                r_periodic;
    logic                r_same;
    t_param              r_first;
    logic [PERIOD_W-1:0] r_period;
    logic [TOL_W-1:0]    r_tol;
    // Bounds around the last parameter, relative to the base
    t_cmp                r_ppt;
    t_cmp                r_pmt;

    logic accept;

    // Stage A: lane selection and difference to the base
    logic    n_sa_force;
    t_param  n_sa_p    [NUM_LANES];
    t_param  n_sa_base [NUM_LANES];
    t_orient n_sa_o    [NUM_LANES];
    logic    n_sa_en   [NUM_LANES];
    t_diff   n_sa_d    [NUM_LANES];

    logic    r_sa_vld;
    logic    r_sa_force;
    t_param  r_sa_p    [NUM_LANES];
    t_param  r_sa_base [NUM_LANES];
    t_orient r_sa_o    [NUM_LANES];
    logic    r_sa_en   [NUM_LANES];
    t_diff   r_sa_d    [NUM_LANES];

    // Stage B and remainder pipeline (index 0 is the tolerance stage output)
    t_lane n_pl0 [NUM_LANES];
    t_div  n_pd0 [NUM_LANES];

    logic  r_pv [0:DIV_STAGES];
    logic  r_pf [0:DIV_STAGES];
    t_lane r_pl [0:DIV_STAGES][NUM_LANES];
    t_div  r_pd [0:DIV_STAGES][NUM_LANES];

    // Fix-up stage
    logic [PERIOD_W-1:0] n_f1_r [NUM_LANES];
    logic                r_f1_vld;
    logic                r_f1_force;
    t_lane               r_f1_lane [NUM_LANES];
    logic [PERIOD_W-1:0] r_f1_r    [NUM_LANES];

    // Value stage
    t_val    n_f2_val [NUM_LANES];
    logic    r_f2_vld;
    logic    r_f2_force;
    t_orient r_f2_o   [NUM_LANES];
    t_val    r_f2_val [NUM_LANES];

    // Output stage
    logic n_out;
    logic r_done;
    logic r_out;

    // One restoring remainder step: shift in one dividend bit, subtract if it fits
    function automatic t_div div_step(input t_div s, input logic [PERIOD_W-1:0] per);
        logic [PERIOD_W:0] trial;
        t_div              nx;
        trial  = {s.rem, s.dvd[FIELD_W-1]};
        nx.dvd = s.dvd << 1;
        if (trial >= {1'b0, per}) begin
            nx.rem = PERIOD_W'(trial - {1'b0, per});
        end else begin
            nx.rem = trial[PERIOD_W-1:0];
        end
        return nx;
    endfunction

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periodic <= 1'b0;
            r_same     <= 1'b0;
            r_first    <= '0;
            r_period   <= '0;
            r_tol      <= TOL_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PERIODIC: r_periodic <= i_cfg_wdata[0];
                REG_SAME:     r_same     <= i_cfg_wdata[0];
                REG_FIRST:    r_first    <= sext_param(i_cfg_wdata[FIELD_W-1:0]);
                REG_PERIOD:   r_period   <= i_cfg_wdata[PERIOD_W-1:0];
                REG_TOL:      r_tol      <= i_cfg_wdata[TOL_W-1:0];
                default:      ;
            endcase
        end
    end

    // Precompute the last-bound window from the configuration
    always_ff @(posedge i_clk) begin
        r_ppt <= t_cmp'({1'b0, r_period}) + t_cmp'({1'b0, r_tol});
        r_pmt <= t_cmp'({1'b0, r_period}) - t_cmp'({1'b0, r_tol});
    end

    // Stage A: pick what each lane adjusts against and take the difference
    always_comb begin
        t_param  pa;
        t_param  pb;
        t_orient oa;
        t_orient ob;
        pa = sext_param(i_param_a);
        pb = sext_param(i_param_b);
        oa = t_orient'(i_orient_a);
        ob = t_orient'(i_orient_b);
        n_sa_force   = r_periodic & ~r_same & (oa == ob);
        n_sa_p[0]    = pa;
        n_sa_p[1]    = pb;
        n_sa_o[0]    = oa;
        n_sa_o[1]    = ob;
        n_sa_base[0] = r_same ? r_first : pb;
        n_sa_base[1] = r_same ? r_first : pa;
        n_sa_en[0]   = r_periodic & (r_same | ((oa != ob) & (ob == OR_FORWARD)));
        n_sa_en[1]   = r_periodic & (r_same | ((oa != ob) & (oa == OR_FORWARD)));
        for (int l = 0; l < NUM_LANES; l++) begin
            n_sa_d[l] = t_diff'(n_sa_p[l]) - t_diff'(n_sa_base[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa_vld <= 1'b0;
        end else begin
            r_sa_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa_force <= n_sa_force;
        r_sa_p     <= n_sa_p;
        r_sa_base  <= n_sa_base;
        r_sa_o     <= n_sa_o;
        r_sa_en    <= n_sa_en;
        r_sa_d     <= n_sa_d;
    end

    // Stage B: tolerance tests, adjust category and remainder operand
    always_comb begin
        t_cmp dx;
        t_cmp tolx;
        logic near_first;
        logic near_last;
        for (int l = 0; l < NUM_LANES; l++) begin
            dx         = t_cmp'(r_sa_d[l]);
            tolx       = t_cmp'({1'b0, r_tol});
            near_first = (dx < tolx) && (dx > -tolx);
            near_last  = (dx < r_ppt) && (dx > r_pmt);
            n_pl0[l].p    = r_sa_p[l];
            n_pl0[l].base = r_sa_base[l];
            n_pl0[l].o    = r_sa_o[l];
            n_pl0[l].neg  = r_sa_d[l][DIFF_W-1];
            priority if (!r_sa_en[l]) begin
                n_pl0[l].cat = ADJ_KEEP;
            end else if (near_first) begin
                n_pl0[l].cat = (r_sa_o[l] == OR_REVERSED) ? ADJ_ADD_P : ADJ_KEEP;
            end else if (near_last) begin
                n_pl0[l].cat = ADJ_KEEP;
            end else if (r_period == '0) begin
                n_pl0[l].cat = ADJ_KEEP;
            end else begin
                n_pl0[l].cat = ADJ_WRAP;
            end
            n_pd0[l].rem = '0;
            n_pd0[l].dvd = r_sa_d[l][DIFF_W-1] ? FIELD_W'(-r_sa_d[l])
                                               : r_sa_d[l][FIELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv[0] <= 1'b0;
        end else begin
            r_pv[0] <= r_sa_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pf[0] <= r_sa_force;
        r_pl[0] <= n_pl0;
        r_pd[0] <= n_pd0;
    end

    // Remainder stages: one bit per stage, sideband follows
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        t_div n_pd [NUM_LANES];

        always_comb begin
            for (int l = 0; l < NUM_LANES; l++) begin
                n_pd[l] = div_step(r_pd[k-1][l], r_period);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv[k] <= 1'b0;
            end else begin
                r_pv[k] <= r_pv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_pf[k] <= r_pf[k-1];
            r_pl[k] <= r_pl[k-1];
            r_pd[k] <= n_pd;
        end
    end

    // Fix-up: turn the magnitude remainder into a floored remainder
    always_comb begin
        logic [PERIOD_W-1:0] rem;
        for (int l = 0; l < NUM_LANES; l++) begin
            rem = r_pd[DIV_STAGES][l].rem;
            if (r_pl[DIV_STAGES][l].neg && (rem != '0)) begin
                n_f1_r[l] = r_period - rem;
            end else begin
                n_f1_r[l] = rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else begin
            r_f1_vld <= r_pv[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_force <= r_pf[DIV_STAGES];
        r_f1_lane  <= r_pl[DIV_STAGES];
        r_f1_r     <= n_f1_r;
    end

    // Value stage: form the adjusted parameter of each lane
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            unique case (r_f1_lane[l].cat)
                ADJ_KEEP:  n_f2_val[l] = t_val'(r_f1_lane[l].p);
                ADJ_ADD_P: n_f2_val[l] = t_val'(r_f1_lane[l].p) + t_val'({1'b0, r_period});
                ADJ_WRAP:  n_f2_val[l] = t_val'(r_f1_lane[l].base) + t_val'({1'b0, r_f1_r[l]});
                default:   n_f2_val[l] = t_val'(r_f1_lane[l].p);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_vld <= 1'b0;
        end else begin
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f2_force <= r_f1_force;
        for (int l = 0; l < NUM_LANES; l++) begin
            r_f2_o[l] <= r_f1_lane[l].o;
        end
        r_f2_val <= n_f2_val;
    end

    // Output stage: order compare, read according to the orientation of b; a forced item is outside
    always_comb begin
        logic lower;
        lower = (r_f2_o[1] == OR_REVERSED);
        if (r_f2_force) begin
            n_out = 1'b1;
        end else begin
            unique case (r_f2_o[1])
                OR_INTERNAL: n_out = 1'b0;
                OR_EXTERNAL: n_out = 1'b1;
                default: begin
                    priority if (r_f2_val[0] == r_f2_val[1]) begin
                        n_out = (r_f2_o[0] != r_f2_o[1]);
                    end else if (r_f2_val[0] < r_f2_val[1]) begin
                        n_out = ~lower;
                    end else begin
                        n_out = lower;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_done       = r_done;
    assign o_is_outside = r_out;

endmodule

// File: test/pvoc_order_checker.sv
// Scoreboard for the periodic vertex order classifier: watches the item, result and
// register write channels, predicts each classification and compares it.
// Depends on pvoc_pkg for widths, orientation codes and register indexes.
`timescale 1ns / 1ps

module pvoc_order_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic [pvoc_pkg::FIELD_W-1:0]    i_param_a,
    input  logic [pvoc_pkg::ORIENT_W-1:0]   i_orient_a,
    input  logic [pvoc_pkg::FIELD_W-1:0]    i_param_b,
    input  logic [pvoc_pkg::ORIENT_W-1:0]   i_orient_b,
    input  logic                            i_cfg_we,
    input  logic [pvoc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pvoc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_done,
    input  logic                            i_is_outside,
    output int                              o_pending,
    output int                              o_errors
);
    import pvoc_pkg::*;

    // Register copy, parameters held at full precision
    bit     cfg_periodic;
    bit     cfg_same;
    longint cfg_first;
    longint cfg_period;
    longint cfg_tol;

    bit expected_outside_q[$];
    bit want_outside;
    int fail_count;
    int result_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch at result %0d: %s", $realtime, result_count, msg);
        fail_count++;
    endtask

    // Cut to the parameter width and sign-extend back
    function automatic longint to_param(input logic [FIELD_W-1:0] raw);
        longint v;
        v = longint'($signed(raw));
        return (v <<< (64 - EFF_W)) >>> (64 - EFF_W);
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Move p into the period range that starts at base, unless p is within tolerance of a bound or the period is zero
    function automatic longint fold_param(input longint p, input t_orient o,
                                          input longint base);
        longint last;
        longint rem;
        last = base + cfg_period;
        if (magnitude(p - base) < cfg_tol)
            return (o == OR_REVERSED) ? p + cfg_period : p;
        if (magnitude(p - last) < cfg_tol)
            return p;
        if (cfg_period == 0)
            return p;
        rem = (p - base) % cfg_period;
        if (rem < 0)
            rem += cfg_period;
        return base + rem;
    endfunction

    // Plain order test of b against a
    function automatic bit order_outside(input longint pa, input t_orient oa,
                                         input longint pb, input t_orient ob);
        if (ob == OR_INTERNAL)
            return 1'b0;
        if (ob == OR_EXTERNAL)
            return 1'b1;
        if (pa == pb)
            return oa != ob;
        if (pa < pb)
            return ob != OR_REVERSED;
        return ob == OR_REVERSED;
    endfunction

    function automatic bit predict_outside(input logic [FIELD_W-1:0] raw_a, input t_orient oa,
                                           input logic [FIELD_W-1:0] raw_b, input t_orient ob);
        longint pa;
        longint pb;
        longint na;
        longint nb;
        pa = to_param(raw_a);
        pb = to_param(raw_b);
        if (!cfg_periodic)
            return order_outside(pa, oa, pb, ob);
        if (cfg_same) begin
            na = fold_param(pa, oa, cfg_first);
            nb = fold_param(pb, ob, cfg_first);
            return order_outside(na, oa, nb, ob);
        end
        if (oa == ob)
            return 1'b1;
        na = pa;
        nb = pb;
        if (oa == OR_FORWARD)
            nb = fold_param(pb, ob, pa);
        if (ob == OR_FORWARD)
            na = fold_param(pa, oa, nb);
        return order_outside(na, oa, nb, ob);
    endfunction

    // Track registers, queue predictions, and check results in order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_periodic = 1'b0;
            cfg_same     = 1'b0;
            cfg_first    = 0;
            cfg_period   = 0;
            cfg_tol      = 1;
            expected_outside_q.delete();
        end else begin
            if (i_done) begin
                if (expected_outside_q.size() == 0) begin
                    report_mismatch($sformatf("result is_outside=%0b with no item waiting",
                                              i_is_outside));
                end else begin
                    want_outside = expected_outside_q.pop_front();
                    if (i_is_outside !== want_outside)
                        report_mismatch($sformatf("is_outside got %0b, want %0b",
                                                  i_is_outside, want_outside));
                end
                result_count++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PERIODIC: cfg_periodic = i_cfg_wdata[0];
                    REG_SAME:     cfg_same     = i_cfg_wdata[0];
                    REG_FIRST:    cfg_first    = to_param(i_cfg_wdata);
                    REG_PERIOD:   cfg_period   = longint'(i_cfg_wdata[PERIOD_W-1:0]);
                    REG_TOL:      cfg_tol      = longint'(i_cfg_wdata[TOL_W-1:0]);
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                expected_outside_q.push_back(predict_outside(i_param_a, t_orient'(i_orient_a),
                                                             i_param_b, t_orient'(i_orient_b)));
        end
        o_pending <= expected_outside_q.size();
        o_errors  <= fail_count;
    end

endmodule

// File: test/periodic_vertex_order_classifier_unit_test.sv
// Testbench top for the periodic vertex order classifier: drives items and register
// writes through several settings and gives the verdict.
// Depends on pvoc_pkg, the classifier unit and the pvoc_order_checker scoreboard.
`timescale 1ns / 1ps

module periodic_vertex_order_classifier_unit_test;
    import pvoc_pkg::*;

    localparam logic [FIELD_W-1:0] PARAM_MIN = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] PARAM_MAX = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] ONE_TURN  = 32'h0001_0000;
    localparam int RAND_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int DRAIN_CYCLES    = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [FIELD_W-1:0]    i_param_a = '0;
    logic [ORIENT_W-1:0]   i_orient_a = OR_FORWARD;
    logic [FIELD_W-1:0]    i_param_b = '0;
    logic [ORIENT_W-1:0]   i_orient_b = OR_FORWARD;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  o_done;
    logic                  o_is_outside;

    int pending;
    int errors;

    // Shadow of the current setting, used to aim parameters at the bounds
    longint cur_first;
    longint cur_period;
    longint cur_tol;

    periodic_vertex_order_classifier_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_param_a    (i_param_a),
        .i_orient_a   (i_orient_a),
        .i_param_b    (i_param_b),
        .i_orient_b   (i_orient_b),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_is_outside (o_is_outside)
    );

    pvoc_order_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_param_a    (i_param_a),
        .i_orient_a   (i_orient_a),
        .i_param_b    (i_param_b),
        .i_orient_b   (i_orient_b),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_done       (o_done),
        .i_is_outside (o_is_outside),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    always #5 i_clk = ~i_clk;

    // Hold one item until the block takes it
    task automatic drive_item(input logic [FIELD_W-1:0] pa, input t_orient oa,
                              input logic [FIELD_W-1:0] pb, input t_orient ob);
        start      <= 1'b1;
        i_param_a  <= pa;
        i_orient_a <= oa;
        i_param_b  <= pb;
        i_orient_b <= ob;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending and wait until every queued classification is back
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Write all registers, with junk in the unused data bits
    task automatic apply_setting(input bit periodic, input bit same,
                                 input logic [FIELD_W-1:0] first,
                                 input logic [PERIOD_W-1:0] period,
                                 input logic [TOL_W-1:0] tol, input bit hit_unused);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom;
        data[0] = periodic;
        reg_write(REG_PERIODIC, data);
        data = $urandom;
        data[0] = same;
        reg_write(REG_SAME, data);
        reg_write(REG_FIRST, first);
        data = $urandom;
        data[PERIOD_W-1:0] = period;
        reg_write(REG_PERIOD, data);
        data = $urandom;
        data[TOL_W-1:0] = tol;
        reg_write(REG_TOL, data);
        if (hit_unused) begin
            for (int k = int'(REG_TOL) + 1; k < (1 << CFG_IDX_W); k++)
                reg_write(k[CFG_IDX_W-1:0], $urandom);
        end
        i_cfg_we   <= 1'b0;
        cur_first  = longint'($signed(first));
        cur_period = longint'(period);
        cur_tol    = longint'(tol);
    endtask

    // Pick a parameter at, near or a few periods away from a bound of base, or a random one
    function automatic logic [FIELD_W-1:0] near_param(input longint base);
        longint span;
        longint v;
        span = cur_tol + 2;
        case ($urandom_range(0, 5))
            0: v = longint'($urandom);
            1: v = base + longint'($urandom_range(0, 2 * span)) - span;
            2: v = base + cur_period + longint'($urandom_range(0, 2 * span)) - span;
            3: begin
                v = base + (longint'($urandom_range(0, 6)) - 3) * cur_period;
                if (cur_period > 0)
                    v += longint'($urandom_range(0, cur_period - 1));
            end
            4: v = base;
            default: v = base + cur_period;
        endcase
        return v[FIELD_W-1:0];
    endfunction

    initial begin
        bit                  s_periodic;
        bit                  s_same;
        logic [FIELD_W-1:0]  s_first;
        logic [PERIOD_W-1:0] s_period;
        logic [TOL_W-1:0]    s_tol;
        logic [FIELD_W-1:0]  pa;
        logic [FIELD_W-1:0]  pb;
        int                  gap_odds;

        cur_first  = 0;
        cur_period = 0;
        cur_tol    = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: plain edge, equal values, extremes, internal and external b
        drive_item(32'h0, OR_FORWARD, 32'h0, OR_FORWARD);
        drive_item(32'h0, OR_FORWARD, 32'h0, OR_REVERSED);
        drive_item(PARAM_MIN, OR_FORWARD, PARAM_MAX, OR_FORWARD);
        drive_item(PARAM_MAX, OR_REVERSED, PARAM_MIN, OR_REVERSED);
        drive_item(PARAM_MIN, OR_INTERNAL, PARAM_MAX, OR_INTERNAL);
        drive_item(PARAM_MAX, OR_EXTERNAL, PARAM_MIN, OR_EXTERNAL);
        drive_item(32'h1234, OR_REVERSED, 32'h1233, OR_FORWARD);
        drain;

        // Shared parameters: values on both bounds and values that wrap
        apply_setting(1'b1, 1'b1, 32'h0, ONE_TURN[PERIOD_W-1:0], 16'h0100, 1'b0);
        drive_item(ONE_TURN, OR_FORWARD, 32'h0, OR_REVERSED);
        drive_item(32'h0002_8000, OR_FORWARD, 32'hFFFF_C000, OR_FORWARD);
        drive_item(32'h0000_0080, OR_REVERSED, 32'h0000_FF80, OR_REVERSED);
        drive_item(32'h0000_4000, OR_INTERNAL, 32'h0000_8000, OR_EXTERNAL);
        drain;

        // Zero tolerance: a value at the last bound wraps to the first
        apply_setting(1'b1, 1'b0, 32'h0, ONE_TURN[PERIOD_W-1:0], 16'h0, 1'b1);
        drive_item(32'h0, OR_FORWARD, ONE_TURN, OR_REVERSED);
        drive_item(32'h0000_5000, OR_REVERSED, 32'h0002_0000, OR_FORWARD);
        drive_item(32'h3, OR_FORWARD, 32'h3, OR_FORWARD);
        drive_item(PARAM_MAX, OR_FORWARD, PARAM_MIN, OR_REVERSED);
        drain;

        // Zero period with the widest tolerance and a wide result range
        apply_setting(1'b1, 1'b1, PARAM_MIN, 31'h0, 16'hFFFF, 1'b0);
        drive_item(PARAM_MIN + 32'd5, OR_REVERSED, PARAM_MAX, OR_FORWARD);
        drive_item(PARAM_MAX, OR_FORWARD, PARAM_MIN + 32'hFFFE, OR_INTERNAL);
        drive_item(PARAM_MIN, OR_FORWARD, PARAM_MIN, OR_REVERSED);
        drain;

        // Random phases, each under its own setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    s_periodic = 1'b1; s_same = 1'b0; s_first = PARAM_MIN;
                    s_period = 31'h7FFF_FFFF; s_tol = 16'hFFFF;
                end
                1: begin
                    s_periodic = 1'b1; s_same = 1'b1; s_first = PARAM_MAX;
                    s_period = 31'h0; s_tol = 16'h0;
                end
                2: begin
                    s_periodic = 1'b1; s_same = 1'b1; s_first = 32'h0;
                    s_period = ONE_TURN[PERIOD_W-1:0]; s_tol = 16'h0080;
                end
                default: begin
                    s_periodic = ($urandom_range(0, 4) != 0);
                    s_same     = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 4))
                        0: s_first = PARAM_MIN;
                        1: s_first = PARAM_MAX;
                        2: s_first = 32'h0;
                        3: s_first = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
                        default: s_first = $urandom;
                    endcase
                    case ($urandom_range(0, 3))
                        0: s_period = 31'h0;
                        1: s_period = 31'h7FFF_FFFF;
                        2: s_period = PERIOD_W'($urandom_range(1, 32'h0004_0000));
                        default: s_period = PERIOD_W'($urandom);
                    endcase
                    case ($urandom_range(0, 3))
                        0: s_tol = 16'h0;
                        1: s_tol = 16'h1;
                        2: s_tol = 16'hFFFF;
                        default: s_tol = TOL_W'($urandom);
                    endcase
                end
            endcase
            apply_setting(s_periodic, s_same, s_first, s_period, s_tol,
                          $urandom_range(0, 3) == 0);

            // No idling in the last phase; otherwise dense, sparse or no gaps
            if (ph == RAND_PHASES - 1)
                gap_odds = 0;
            else
                case ($urandom_range(0, 2))
                    0: gap_odds = 0;
                    1: gap_odds = 8;
                    default: gap_odds = 3;
                endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pa = near_param(cur_first);
                if ($urandom_range(0, 1))
                    pb = near_param(longint'($signed(pa)));
                else
                    pb = near_param(cur_first);
                drive_item(pa, t_orient'($urandom_range(0, 3)), pb,
                           t_orient'($urandom_range(0, 3)));
                if (ph == 4 && n == ITEMS_PER_PHASE / 2)
                    drain;
                else if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
                    idle_cycles($urandom_range(1, 16));
            end
            drain;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("periodic_vertex_order_classifier_unit_test: PASS");
        else
            $display("periodic_vertex_order_classifier_unit_test: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("periodic_vertex_order_classifier_unit_test: FAIL");
        $finish;
    end

endmodule

// File: periodic_vertex_order_classifier_unit.f
design/pvoc_pkg.sv
design/periodic_vertex_order_classifier_unit.sv
test/pvoc_order_checker.sv
test/periodic_vertex_order_classifier_unit_test.sv
